[rtl/rpcca_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpcca_pkg: shared types, constants and the CRC-32 byte update
// Types for one result item and the push bundle into the result queue.
// ----------------------------------------------------------------------------
package rpcca_pkg;

    localparam int MAX_PACKET_BYTES = 255;
    localparam int FILE_COUNT_BITS  = 16;

    localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 1);
    localparam int MIN_PACKET_BYTES = 6;
    localparam int CRC_BYTES        = 4;
    localparam int HEADER_BYTES     = 3;

    localparam logic [7:0]  ACK_MATCH    = 8'hAA;
    localparam logic [7:0]  ACK_MISMATCH = 8'hFF;
    localparam logic [7:0]  ACK_NONE     = 8'h00;
    localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT     = 32'hFFFFFFFF;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        KIND_DATA   = 1'b0,
        KIND_STATUS = 1'b1
    } kind_t;

    typedef struct packed {
        logic [15:0] file_number;
        logic        file_done;
        logic [7:0]  ack_code;
        logic        length_error;
        logic        crc_ok;
        logic [7:0]  seq_total;
        logic [7:0]  ack_seq;
        logic [7:0]  packet_type;
        logic [7:0]  data_byte;
        kind_t       kind;
        logic        end_of_run;
    } result_t;

    // Results caused by one accepted byte, already in output order.
    typedef struct packed {
        logic [1:0] num;
        result_t    first;
        result_t    second;
    } push_t;

    // Reflected CRC-32 update over one byte.
    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[rtl/rpcca_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpcca_core: per-packet state, CRC tracking and result build
// Updates packet state on each accepted byte and forms up to two results.
// ----------------------------------------------------------------------------
module rpcca_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_accept,
    input  logic [7:0]           in_byte,
    input  logic                 in_last,
    output rpcca_pkg::push_t     push
);

    localparam int PW = rpcca_pkg::POS_W;
    localparam int FW = rpcca_pkg::FILE_COUNT_BITS;

    logic [PW-1:0] pos_reg,      pos_next;
    logic          too_long_reg, too_long_next;
    logic [31:0]   crc_reg,      crc_next;
    logic [7:0]    tail_reg [4];
    logic [7:0]    tail_next [4];
    logic [7:0]    type_reg,     type_next;
    logic [7:0]    seq_reg,      seq_next;
    logic [7:0]    count_reg,    count_next;
    logic [FW-1:0] file_reg,     file_next;

    logic          leave_valid;
    logic          leave_data;
    logic [31:0]   crc_upd;
    logic [PW:0]   len;
    logic          len_err;
    logic          ok;
    logic          done;
    logic [31:0]   rx_crc;
    logic [31:0]   file_ext;
    rpcca_pkg::result_t data_res;
    rpcca_pkg::result_t stat_res;

    always_comb begin
        leave_valid = too_long_reg || (pos_reg >= PW'(rpcca_pkg::CRC_BYTES));
        leave_data  = too_long_reg ||
                      (pos_reg >= PW'(rpcca_pkg::CRC_BYTES + rpcca_pkg::HEADER_BYTES));
        crc_upd     = leave_valid ? rpcca_pkg::crc_byte(crc_reg, tail_reg[0]) : crc_reg;

        type_next  = (pos_reg == PW'(0) && !too_long_reg) ? in_byte : type_reg;
        seq_next   = (pos_reg == PW'(1) && !too_long_reg) ? in_byte : seq_reg;
        count_next = (pos_reg == PW'(2) && !too_long_reg) ? in_byte : count_reg;

        tail_next[0] = tail_reg[1];
        tail_next[1] = tail_reg[2];
        tail_next[2] = tail_reg[3];
        tail_next[3] = in_byte;

        len = {1'b0, pos_reg} + (PW+1)'(1);
        if (pos_reg >= PW'(rpcca_pkg::MAX_PACKET_BYTES)) begin
            too_long_next = 1'b1;
            pos_next      = pos_reg;
        end else begin
            too_long_next = too_long_reg;
            pos_next      = pos_reg + PW'(1);
        end

        len_err  = too_long_next || (len < (PW+1)'(rpcca_pkg::MIN_PACKET_BYTES));
        rx_crc   = {in_byte, tail_reg[3], tail_reg[2], tail_reg[1]};
        ok       = !len_err && ((crc_upd ^ rpcca_pkg::CRC_INIT) == rx_crc);
        done     = !len_err && (type_next == 8'd0) && ((seq_next + 8'd1) == count_next);
        file_ext = 32'(file_reg);

        data_res            = '0;
        data_res.kind       = rpcca_pkg::KIND_DATA;
        data_res.data_byte  = tail_reg[0];
        data_res.end_of_run = !in_last;

        stat_res              = '0;
        stat_res.kind         = rpcca_pkg::KIND_STATUS;
        stat_res.packet_type  = type_next;
        stat_res.ack_seq      = seq_next;
        stat_res.seq_total    = count_next;
        stat_res.crc_ok       = ok;
        stat_res.length_error = len_err;
        stat_res.ack_code     = len_err ? rpcca_pkg::ACK_NONE :
                                (ok ? rpcca_pkg::ACK_MATCH : rpcca_pkg::ACK_MISMATCH);
        stat_res.file_done    = done;
        stat_res.file_number  = file_ext[15:0];
        stat_res.end_of_run   = 1'b1;

        push        = '0;
        push.second = stat_res;
        if (in_accept) begin
            if (leave_data) begin
                push.first = data_res;
                push.num   = in_last ? 2'd2 : 2'd1;
            end else begin
                push.first = stat_res;
                push.num   = in_last ? 2'd1 : 2'd0;
            end
        end else begin
            push.first = data_res;
        end

        file_next = (in_last && done) ? file_reg + FW'(1) : file_reg;
        crc_next  = crc_upd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (in_accept && in_last)) begin
            pos_reg      <= '0;
            too_long_reg <= 1'b0;
            crc_reg      <= rpcca_pkg::CRC_INIT;
            type_reg     <= '0;
            seq_reg      <= '0;
            count_reg    <= '0;
            for (int i = 0; i < 4; i++) begin
                tail_reg[i] <= '0;
            end
        end else if (in_accept) begin
            pos_reg      <= pos_next;
            too_long_reg <= too_long_next;
            crc_reg      <= crc_next;
            type_reg     <= type_next;
            seq_reg      <= seq_next;
            count_reg    <= count_next;
            for (int i = 0; i < 4; i++) begin
                tail_reg[i] <= tail_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            file_reg <= FW'(1);
        end else if (in_accept) begin
            file_reg <= file_next;
        end
    end

endmodule

[rtl/rpcca_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpcca_queue: small result queue
// Takes up to two results per cycle, delivers one per cycle while pop is high.
// ----------------------------------------------------------------------------
module rpcca_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rpcca_pkg::push_t     push,
    input  logic                 pop,
    output logic                 room_two,
    output logic                 not_empty,
    output rpcca_pkg::result_t   head
);

    localparam int PW = rpcca_pkg::QPTR_W;
    localparam int CW = rpcca_pkg::QCNT_W;

    rpcca_pkg::result_t slot_reg [rpcca_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_pop;

    always_comb begin
        do_pop    = pop && (cnt_reg != '0);
        wr_next   = wr_reg + PW'(push.num);
        rd_next   = do_pop ? rd_reg + PW'(1) : rd_reg;
        cnt_next  = cnt_reg + CW'(push.num) - CW'(do_pop);
        room_two  = cnt_reg <= CW'(rpcca_pkg::QUEUE_DEPTH - 2);
        not_empty = cnt_reg != '0;
        head      = slot_reg[rd_reg];
    end

    always_ff @(posedge aclk) begin
        if (push.num != 2'd0) begin
            slot_reg[wr_reg] <= push.first;
        end
        if (push.num == 2'd2) begin
            slot_reg[wr_reg + PW'(1)] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

[rtl/radio_packet_crc_check_ack.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radio_packet_crc_check_ack: received packet CRC-32 check with ACK code
// Streams packet bytes through, emits data bytes and one status item per packet.
// ----------------------------------------------------------------------------
// One packet byte enters per accepted input item, with s_axis_tlast on the final
// byte. Packet layout: type, sequence, sequence count, data, then a little-endian
// CRC-32 (reflected, all-ones start, final inversion) over all bytes before it.
// Data bytes come out as they leave a four-byte delay line, so output lags input
// by four bytes; keep them only if the packet's status item reports crc_ok. The
// final byte also yields a status item (m_axis_tuser high) with the verdict, the
// ACK code (0xAA match, 0xFF mismatch, 0x00 on length error), the echoed header
// and the file counter. Rate: one byte per clock; each byte passes through the
// byte-wise CRC update and is pushed into a four-entry result queue.
// The final byte of a packet may push two items, so the input stalls only when
// the queue holds more than two items, i.e. when the consumer falls behind.
// Items pushed by an accepted byte are registered in the queue before they are offered.
module radio_packet_crc_check_ack (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] data_byte, [15:8] packet_type, [23:16] ack_seq, [31:24] seq_total,
    // [32] crc_ok, [33] length_error, [41:34] ack_code, [42] file_done,
    // [58:43] file_number, [63:59] zero
    output logic [63:0] m_axis_tdata,
    output logic        m_axis_tuser,   // kind
    output logic        m_axis_tlast    // end_of_run
);

    rpcca_pkg::push_t   push;
    rpcca_pkg::result_t head;
    logic               room_two;
    logic               not_empty;
    logic               in_accept;

    // Accept only while the queue can take both items of a final byte.
    assign s_axis_tready = room_two;
    assign in_accept     = s_axis_tvalid && room_two;

    rpcca_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_byte   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .push      (push)
    );

    rpcca_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .pop       (m_axis_tready),
        .room_two  (room_two),
        .not_empty (not_empty),
        .head      (head)
    );

    // Pack the head result onto the master side.
    assign m_axis_tvalid = not_empty;
    assign m_axis_tuser  = head.kind;
    assign m_axis_tlast  = head.end_of_run;
    assign m_axis_tdata  = {5'd0, head.file_number, head.file_done, head.ack_code,
                            head.length_error, head.crc_ok, head.seq_total,
                            head.ack_seq, head.packet_type, head.data_byte};

endmodule
